/* design/ivp_pkg.sv */
// Package for the IPv4 range text parser: payload types, phase and status codes, constants.
package ivp_pkg;

    localparam int LENGTH_BITS_DEF = 8;

    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [11:0] PREFIX_MAX = 12'd32;
    localparam logic [7:0]  USED_MAX   = 8'd255;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_SECOND = 3'd2,
        PH_PREFIX = 3'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SYNTAX   = 3'd1,
        ST_OCTET    = 3'd2,
        ST_REVERSED = 3'd3,
        ST_PREFIX   = 3'd4,
        ST_HOSTBITS = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] first_addr;
        logic [31:0] last_addr;
        logic [7:0]  used_length;
    } out_item_t;

endpackage

/* design/ivp_core.sv */
// Parser state registers and the one-character step logic.
module ivp_core #(
    parameter int LENGTH_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  ivp_pkg::in_item_t item,
    output logic              res_valid,
    output ivp_pkg::out_item_t res_item
);
    import ivp_pkg::*;

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic [1:0]             idx_reg, idx_next;
    logic [8:0]             acc_reg, acc_next;
    logic                   seen_reg, seen_next;
    logic [31:0]            lo_reg, lo_next;
    logic [31:0]            hi_reg, hi_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;

    // state as seen by this character (a start flag restarts the record)
    phase_t                 e_phase;
    logic [1:0]             e_idx;
    logic [8:0]             e_acc;
    logic                   e_seen;
    logic [31:0]            e_lo, e_hi;
    logic [LENGTH_BITS-1:0] e_cnt;

    logic                   dig;
    logic [3:0]             dval;
    logic [11:0]            prod;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic [31:0]            addr_cur, addr_shift, mask;
    logic [15:0]            cnt_wide;
    logic                   emit;

    assign e_phase = item.start_req ? PH_FIRST : phase_reg;
    assign e_idx   = item.start_req ? 2'd0 : idx_reg;
    assign e_acc   = item.start_req ? 9'd0 : acc_reg;
    assign e_seen  = item.start_req ? 1'b0 : seen_reg;
    assign e_lo    = item.start_req ? 32'd0 : lo_reg;
    assign e_hi    = item.start_req ? 32'd0 : hi_reg;
    assign e_cnt   = item.start_req ? '0 : cnt_reg;

    assign dig  = (item.ch >= CHAR_ZERO) && (item.ch <= CHAR_NINE);
    assign dval = dig ? 4'(item.ch - CHAR_ZERO) : 4'd0;
    // acc * 10 + digit as two shifts and adds
    assign prod = {e_acc, 3'b000} + {2'b00, e_acc, 1'b0} + {8'd0, dval};

    assign cnt_inc    = (e_cnt == CNT_MAX) ? e_cnt : e_cnt + 1'b1;
    assign addr_cur   = (e_phase == PH_FIRST) ? e_lo : e_hi;
    assign addr_shift = {addr_cur[23:0], e_acc[7:0]};
    assign mask       = (e_acc >= 9'd32) ? 32'd0 : (32'hFFFF_FFFF >> e_acc[4:0]);
    assign cnt_wide   = 16'(e_cnt);

    // result decode
    always_comb begin
        emit                 = 1'b0;
        res_item.status      = ST_OK;
        res_item.first_addr  = 32'd0;
        res_item.last_addr   = 32'd0;
        res_item.used_length = (cnt_wide > 16'(USED_MAX)) ? USED_MAX : cnt_wide[7:0];
        unique case (e_phase)
            PH_FIRST, PH_SECOND: begin
                if (dig) begin
                    if (prod > OCTET_MAX) begin
                        emit            = 1'b1;
                        res_item.status = ST_OCTET;
                    end
                end else if (!e_seen) begin
                    emit            = 1'b1;
                    res_item.status = ST_SYNTAX;
                end else if (e_idx != 2'd3) begin
                    if (item.ch != CHAR_DOT) begin
                        emit            = 1'b1;
                        res_item.status = ST_SYNTAX;
                    end
                end else if (e_phase == PH_FIRST) begin
                    if (item.ch != CHAR_HYPHEN && item.ch != CHAR_SLASH) begin
                        emit                = 1'b1;
                        res_item.first_addr = addr_shift;
                        res_item.last_addr  = addr_shift;
                    end
                end else begin
                    emit = 1'b1;
                    if (e_lo > addr_shift) begin
                        res_item.status = ST_REVERSED;
                    end else begin
                        res_item.first_addr = e_lo;
                        res_item.last_addr  = addr_shift;
                    end
                end
            end
            PH_PREFIX: begin
                if (dig) begin
                    if (prod > PREFIX_MAX) begin
                        emit            = 1'b1;
                        res_item.status = ST_PREFIX;
                    end
                end else begin
                    emit = 1'b1;
                    if ((e_lo & mask) != 32'd0) begin
                        res_item.status = ST_HOSTBITS;
                    end else begin
                        res_item.first_addr = e_lo;
                        res_item.last_addr  = e_lo | mask;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        res_valid = emit;
    end

    // next state
    always_comb begin
        phase_next = e_phase;
        idx_next   = e_idx;
        acc_next   = e_acc;
        seen_next  = e_seen;
        lo_next    = e_lo;
        hi_next    = e_hi;
        cnt_next   = e_cnt;
        if (emit) begin
            phase_next = PH_IDLE;
        end else if (e_phase != PH_IDLE) begin
            cnt_next = cnt_inc;
            if (dig) begin
                acc_next  = prod[8:0];
                seen_next = 1'b1;
            end else if (e_phase == PH_FIRST || e_phase == PH_SECOND) begin
                acc_next  = 9'd0;
                seen_next = 1'b0;
                if (e_phase == PH_FIRST) begin
                    lo_next = addr_shift;
                end else begin
                    hi_next = addr_shift;
                end
                if (e_idx != 2'd3) begin
                    idx_next = e_idx + 2'd1;
                end else if (item.ch == CHAR_HYPHEN) begin
                    phase_next = PH_SECOND;
                    idx_next   = 2'd0;
                end else begin
                    phase_next = PH_PREFIX;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            idx_reg   <= 2'd0;
            acc_reg   <= 9'd0;
            seen_reg  <= 1'b0;
            lo_reg    <= 32'd0;
            hi_reg    <= 32'd0;
            cnt_reg   <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* design/ipv4_range_text_parser.sv */
// Top level of the IPv4 range text parser: input register, parser core, result register.
//
//   channel | ports                       | transfer carries
//   --------+-----------------------------+-----------------------------------------
//   input   | s_valid, s_ready, s_item    | one character and its start flag
//   result  | m_valid, m_ready, m_item    | status, first/last address, used length
//
// One character per cycle sustained while the result side is not stalled.
// A character is captured in the input register, then runs through the
// parser step logic once the result slot is free and, if it ends a record,
// lands in the result register, which drives m_valid. Characters that end
// no record leave no result.
// aresetn (synchronous, active low) empties both registers and parks the
// parser idle. A stalled result holds the input register; s_ready follows
// m_ready combinationally through that one stage.
module ipv4_range_text_parser #(
    parameter int LENGTH_BITS = ivp_pkg::LENGTH_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ivp_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ivp_pkg::out_item_t m_item
);
    import ivp_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      advance;
    logic      res_valid;
    out_item_t res_item;

    // the held character steps the parser once the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    ivp_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .item     (in_item_reg),
        .res_valid(res_valid),
        .res_item (res_item)
    );

    // result register: loads on a result, clears when taken with nothing new
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_item_reg <= res_item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
